### rtl/assert_macros.svh
// assertion macros used by the tone generator core (dtg_core)
// expects a clock and an active-low reset to be passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DTG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dtg assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DTG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dtg assertion failed");

`endif

### rtl/dtg_pkg.sv
// shared types and constants for the decaying tone generator
// no dependencies; used by dtg_div, dtg_core and decaying_tone_generator
`timescale 1ns / 1ps

package dtg_pkg;

  // default width of the elapsed sample counter
  localparam int COUNT_BITS_DEF = 16;

  // shared divider geometry
  localparam int DIV_W          = 32;
  localparam int DSR_W          = 16;
  localparam int DIV_BITS_CYC   = 2;
  localparam int DIV_CYCLES     = DIV_W / DIV_BITS_CYC;

  // configuration register indexes
  localparam logic CFG_OUT_RATE   = 1'b0;
  localparam logic CFG_PEAK_LEVEL = 1'b1;

  // configuration reset values
  localparam logic [15:0] OUT_RATE_RST   = 16'd22050;
  localparam logic [14:0] PEAK_LEVEL_RST = 15'd12000;

  // item kinds and waveforms
  localparam logic       MODE_TRIGGER = 1'b1;
  localparam logic [1:0] WAVE_SQUARE  = 2'd0;
  localparam logic [1:0] WAVE_SAW     = 2'd1;

  // noise generator
  localparam logic [15:0] NOISE_SEED = 16'hACE1;
  localparam logic [15:0] NOISE_TAPS = 16'hB400;

  typedef struct packed {
    logic        mode;
    logic [15:0] tone_frequency;
    logic [15:0] tone_length;
    logic [1:0]  wave_select;
  } item_t;

  typedef struct packed {
    logic [15:0] out_rate;
    logic [14:0] peak_level;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               still_playing;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/decaying_tone_generator.sv
// top level of the decaying tone generator: stream ports, config registers, output register
// depends on dtg_pkg and dtg_core
`timescale 1ns / 1ps

// One-voice tone generator with linear decay. A trigger transaction (tuser 1) gives no
// output; with a nonzero length it stores the frequency, length and waveform and restarts
// the tone. A sample transaction (tuser 0) gives one signed 16-bit sample and a
// still-playing flag. Work on a sample runs through one shared divider that retires two
// quotient bits per cycle under a small sequencer: a playing sample divides for the period,
// the phase and the amplitude, and once more for a saw or noise wave; an idle sample and a
// trigger do not use the divider. The output register lets the next item be taken while a
// sample waits on the master side. Configuration writes belong in idle periods.

module decaying_tone_generator #(
  parameter int COUNT_BITS = dtg_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // tone_frequency[15:0], tone_length[31:16],
                                        // wave_select[33:32], zero fill
  input  logic        s_axis_tuser_i,   // mode
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // sample_out[15:0], still_playing[16], zero fill
);

  dtg_pkg::cfg_t  cfg_q;
  dtg_pkg::item_t item;
  dtg_pkg::res_t  core_res;
  logic           core_ready, core_valid, core_take;
  logic           m_valid_q;
  dtg_pkg::res_t  m_res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_rate   <= dtg_pkg::OUT_RATE_RST;
      cfg_q.peak_level <= dtg_pkg::PEAK_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtg_pkg::CFG_OUT_RATE:   cfg_q.out_rate   <= cfg_wdata_i;
        dtg_pkg::CFG_PEAK_LEVEL: cfg_q.peak_level <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  assign item = '{mode:           s_axis_tuser_i,
                  tone_frequency: s_axis_tdata_i[15:0],
                  tone_length:    s_axis_tdata_i[31:16],
                  wave_select:    s_axis_tdata_i[33:32]};

  assign s_axis_tready_o = core_ready;
  assign core_take       = !m_valid_q || m_axis_tready_i;

  dtg_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (s_axis_tvalid_i && core_ready),
    .item_i      (item),
    .ready_o     (core_ready),
    .res_valid_o (core_valid),
    .res_ready_i (core_take),
    .res_o       (core_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (core_valid && core_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid && core_take) begin
      m_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_res_q.still_playing, m_res_q.sample_out};

endmodule

### rtl/dtg_div.sv
// shared iterative unsigned divider, two quotient bits per cycle
// depends on dtg_pkg for widths and the status struct
`timescale 1ns / 1ps

module dtg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dtg_pkg::DIV_W-1:0]   dividend_i,
  input  logic [dtg_pkg::DSR_W-1:0]   divisor_i,
  output logic [dtg_pkg::DIV_W-1:0]   quotient_o,
  output logic [dtg_pkg::DSR_W-1:0]   remainder_o,
  output dtg_pkg::div_stat_t          stat_o
);

  localparam int DW = dtg_pkg::DIV_W;
  localparam int SW = dtg_pkg::DSR_W;
  localparam int CW = $clog2(dtg_pkg::DIV_CYCLES);
  localparam logic [CW-1:0] LAST = CW'(dtg_pkg::DIV_CYCLES - 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] dsr_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [SW:0]   trial;
  logic          ge;

  // restoring division steps, combinational
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = '0;
    ge    = 1'b0;
    for (int k = 0; k < dtg_pkg::DIV_BITS_CYC; k++) begin
      trial = {rem_d, dvd_d[DW-1]};
      ge    = (trial >= {1'b0, dsr_q});
      if (ge) begin
        rem_d = SW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[SW-1:0];
      end
      dvd_d = {dvd_d[DW-2:0], ge};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule

### rtl/dtg_core.sv
// sequencer and tone state: drives the shared divider and multiplier per sample
// depends on dtg_pkg, dtg_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtg_core #(
  parameter int COUNT_BITS = dtg_pkg::COUNT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtg_pkg::cfg_t  cfg_i,
  input  logic           start_i,
  input  dtg_pkg::item_t item_i,
  output logic           ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output dtg_pkg::res_t  res_o
);

  localparam int DW = dtg_pkg::DIV_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PER_W   = 4'd1;
  localparam logic [3:0] S_PH_W    = 4'd2;
  localparam logic [3:0] S_MUL_AMP = 4'd3;
  localparam logic [3:0] S_AMP_S   = 4'd4;
  localparam logic [3:0] S_AMP_W   = 4'd5;
  localparam logic [3:0] S_WAVE    = 4'd6;
  localparam logic [3:0] S_SAW_S   = 4'd7;
  localparam logic [3:0] S_SAW_W   = 4'd8;
  localparam logic [3:0] S_NOI_S   = 4'd9;
  localparam logic [3:0] S_NOI_W   = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0]            state_q, state_d;
  logic                  playing_q, playing_d;
  logic [15:0]           freq_q, freq_d;
  logic [15:0]           len_q, len_d;
  logic [1:0]            wave_q, wave_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [15:0]           lfsr_q, lfsr_d;
  logic [15:0]           period_q, period_d;
  logic [15:0]           phase_q, phase_d;
  logic [14:0]           amp_q, amp_d;
  logic [31:0]           prod_q, prod_d;
  logic [15:0]           res_q, res_d;

  logic                  div_start;
  logic [DW-1:0]         div_dvd;
  logic [15:0]           div_dsr;
  logic [DW-1:0]         div_quo;
  logic [15:0]           div_rem;
  dtg_pkg::div_stat_t    div_stat;

  logic [15:0]           mul_a, mul_b;
  logic [31:0]           mul_p;

  logic [DW-1:0]         cnt_x, len_x, cnt_inc_x;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [15:0]           per_new;
  logic [15:0]           amp_ext;

  dtg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  // shared multiplier, result always registered in prod_q
  assign mul_p = mul_a * mul_b;

  assign cnt_x     = DW'(cnt_q);
  assign len_x     = DW'(len_q);
  assign cnt_inc   = cnt_q + 1'b1;
  assign cnt_inc_x = DW'(cnt_inc);
  assign per_new   = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
  assign amp_ext   = {1'b0, amp_q};

  // sequencer
  always_comb begin
    state_d   = state_q;
    playing_d = playing_q;
    freq_d    = freq_q;
    len_d     = len_q;
    wave_d    = wave_q;
    cnt_d     = cnt_q;
    lfsr_d    = lfsr_q;
    period_d  = period_q;
    phase_d   = phase_q;
    amp_d     = amp_q;
    prod_d    = prod_q;
    res_d     = res_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (item_i.mode == dtg_pkg::MODE_TRIGGER) begin
            if (item_i.tone_length != 16'd0) begin
              playing_d = 1'b1;
              freq_d    = item_i.tone_frequency;
              len_d     = item_i.tone_length;
              wave_d    = item_i.wave_select;
              cnt_d     = '0;
            end
          end else if (!playing_q) begin
            res_d   = '0;
            state_d = S_FIN;
          end else begin
            div_start = 1'b1;
            div_dvd   = DW'(cfg_i.out_rate);
            div_dsr   = (freq_q == 16'd0) ? 16'd1 : freq_q;
            state_d   = S_PER_W;
          end
        end
      end
      S_PER_W: begin
        if (div_stat.done) begin
          period_d  = per_new;
          div_start = 1'b1;
          div_dvd   = cnt_x;
          div_dsr   = per_new;
          state_d   = S_PH_W;
        end
      end
      S_PH_W: begin
        if (div_stat.done) begin
          phase_d = div_rem;
          if (cnt_x >= len_x) begin
            amp_d   = '0;
            state_d = S_WAVE;
          end else begin
            state_d = S_MUL_AMP;
          end
        end
      end
      S_MUL_AMP: begin
        mul_a   = {1'b0, cfg_i.peak_level};
        mul_b   = len_q - cnt_x[15:0];
        prod_d  = mul_p;
        state_d = S_AMP_S;
      end
      S_AMP_S: begin
        div_start = 1'b1;
        div_dvd   = DW'(prod_q);
        div_dsr   = len_q;
        state_d   = S_AMP_W;
      end
      S_AMP_W: begin
        if (div_stat.done) begin
          amp_d   = div_quo[14:0];
          state_d = S_WAVE;
        end
      end
      S_WAVE: begin
        case (wave_q)
          dtg_pkg::WAVE_SQUARE: begin
            res_d   = (phase_q < (period_q >> 1)) ? amp_ext : 16'd0 - amp_ext;
            state_d = S_FIN;
          end
          dtg_pkg::WAVE_SAW: begin
            mul_a   = phase_q;
            mul_b   = {amp_q, 1'b0};
            prod_d  = mul_p;
            state_d = S_SAW_S;
          end
          default: begin
            lfsr_d  = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? dtg_pkg::NOISE_TAPS : 16'd0);
            state_d = S_NOI_S;
          end
        endcase
      end
      S_SAW_S: begin
        div_start = 1'b1;
        div_dvd   = DW'(prod_q);
        div_dsr   = period_q;
        state_d   = S_SAW_W;
      end
      S_SAW_W: begin
        if (div_stat.done) begin
          res_d   = div_quo[15:0] - amp_ext;
          state_d = S_FIN;
        end
      end
      S_NOI_S: begin
        div_start = 1'b1;
        div_dvd   = DW'(lfsr_q);
        div_dsr   = {amp_q, 1'b1};
        state_d   = S_NOI_W;
      end
      S_NOI_W: begin
        if (div_stat.done) begin
          res_d   = div_rem - amp_ext;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready_i) begin
          if (playing_q) begin
            cnt_d     = cnt_inc;
            playing_d = (cnt_inc_x < len_x);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      playing_q <= 1'b0;
      freq_q    <= '0;
      len_q     <= '0;
      wave_q    <= '0;
      cnt_q     <= '0;
      lfsr_q    <= dtg_pkg::NOISE_SEED;
    end else begin
      state_q   <= state_d;
      playing_q <= playing_d;
      freq_q    <= freq_d;
      len_q     <= len_d;
      wave_q    <= wave_d;
      cnt_q     <= cnt_d;
      lfsr_q    <= lfsr_d;
    end
  end

  // per-sample working values
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    phase_q  <= phase_d;
    amp_q    <= amp_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = '{sample_out:    res_q,
                         still_playing: playing_q && (cnt_inc_x < len_x)};

  // checks
  `DTG_ASSERT_IMP(a_div_start_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `DTG_ASSERT_NXT(a_div_runs, clk_i, rst_ni, div_start, div_stat.busy)
  `DTG_ASSERT_IMP(a_div_done_waited, clk_i, rst_ni, div_stat.done,
                  state_q == S_PER_W || state_q == S_PH_W || state_q == S_AMP_W ||
                  state_q == S_SAW_W || state_q == S_NOI_W)
  `DTG_ASSERT_IMP(a_idle_sample_zero, clk_i, rst_ni, state_q == S_FIN && !playing_q,
                  res_q == 16'd0)

endmodule
